// ===== hdl/mrts_pkg.sv =====
// mrts_pkg: shared types and constants for the multi-rate tick task scheduler
// no dependencies
package mrts_pkg;
  localparam int MAX_TASKS = 8;
  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [20:0] BASE_CLOCK = 21'd1193182;
  localparam logic [16:0] PERIOD_CAP = 17'h10000;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_ADD    = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_START  = 3'd3;
  localparam logic [2:0] MODE_RATE   = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;

  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_FREE = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  slot;
    logic [20:0] tick_base;
    logic [7:0]  priority_req;
    logic [15:0] task_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot_out;
    logic [15:0] tag_out;
    logic [16:0] service_period;
    logic        legacy_tick;
    logic [1:0]  status;
    logic        last;
  } rsp_t;
endpackage

// ===== hdl/mrts_if.sv =====
// mrts_if: valid/ready channel carrying one payload
// depends on mrts_pkg
interface mrts_req_if import mrts_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrts_rsp_if import mrts_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/mrts_div.sv =====
// mrts_div: restoring divider, one quotient bit per cycle, base clock by rate
// depends on mrts_pkg
module mrts_div import mrts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [20:0] rate,
  output logic        done,
  output logic [20:0] quot
);
  logic [20:0] q_r, q_nxt, d_r, d_nxt;
  logic [21:0] rem_r, rem_nxt, trial;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  assign trial = {rem_r[20:0], q_r[20]} - {1'b0, d_r};

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = BASE_CLOCK;
      d_nxt = (rate == 21'd0) ? 21'd1 : (rate > BASE_CLOCK) ? BASE_CLOCK : rate;
      rem_nxt = '0; cnt_nxt = 5'd21; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[21]) begin
        rem_nxt = trial;
        q_nxt = {q_r[19:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[20:0], q_r[20]};
        q_nxt = {q_r[19:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ===== hdl/multi_rate_tick_task_scheduler.sv =====
// multi_rate_tick_task_scheduler: top level with task table memory and sequencer
// depends on mrts_pkg, mrts_if, mrts_div
//
// usage: one request enters on the in_ channel, results leave on out_,
// both valid/ready. a tick gives one fired result per active task that
// reaches its period, in priority order, then a tick-finished result with
// last set. every other mode gives a single acknowledge.
// one request is worked at a time; in_ is ready only when idle with the
// result register empty. the task table memory has one registered read
// port. a tick walks the table slot by slot, reading each entry and then
// updating it if active, and waits whenever the result register is full.
// a remove rescans the remaining entries for the new service period. an
// add runs the divider (21 divider steps); a rate change runs it, then
// rewrites the entry and rescans. other and refused requests go straight to the ack.
// at reset the table is empty and the service period is 65536; the
// table contents need no clearing since only slots in use are read.
// a stalled receiver holds the result register; the walk waits on it.
module multi_rate_tick_task_scheduler import mrts_pkg::*; (
  input logic clk,
  input logic rst_n,
  mrts_req_if.sink   in_req,
  mrts_rsp_if.source out_rsp
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_INS = 4'd2,
    S_RD = 4'd3, S_EX = 4'd4, S_TEND = 4'd5, S_ACK = 4'd6, S_OUT = 4'd7,
    S_SCAN = 4'd8;

  typedef struct packed {
    logic [20:0] period;
    logic [21:0] accum;
    logic [15:0] tag;
  } ent_t;

  ent_t mem [MAX_TASKS];
  ent_t rd_r;
  logic [SW-1:0] rd_addr;
  logic          we;
  logic [SW-1:0] wa;
  ent_t          wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[rd_addr];
  end

  logic [MAX_TASKS-1:0] used_r, active_r;
  logic [7:0]    prio_r [MAX_TASKS];
  logic [SW-1:0] ord_r [MAX_TASKS];
  logic [CW-1:0] cnt_r, idx_r;
  logic [16:0]   cur_r, best_r;
  logic [15:0]   leg_r;
  logic [3:0]    st_r;
  req_t          q_r;
  rsp_t          o_r;
  logic          ov_r;
  logic [SW-1:0] free_s;
  logic          has_free;
  logic          dstart, ddone;
  logic [20:0]   dq;
  logic [21:0]   acc_sum;
  logic [16:0]   leg_sum;
  logic          wa_ok_r, ok_r;
  logic          go, fire, mem_we, ov_load;

  mrts_div u_div (.clk, .rst_n, .start(dstart), .rate(in_req.data.tick_base),
    .done(ddone), .quot(dq));

  always_comb begin
    free_s = '0; has_free = 1'b0;
    for (int i = MAX_TASKS - 1; i >= 0; i--)
      if (!used_r[i]) begin free_s = SW'(i); has_free = 1'b1; end
  end

  assign rd_addr = (st_r == S_DIV) ? q_r.slot[SW-1:0] : ord_r[idx_r[SW-1:0]];
  assign acc_sum = rd_r.accum + {5'd0, cur_r};
  assign leg_sum = {1'b0, leg_r} + cur_r;
  assign in_req.ready = (st_r == S_IDLE) && !ov_r;
  assign out_rsp.valid = ov_r;
  assign out_rsp.data = o_r;
  assign dstart = (st_r == S_IDLE) && in_req.valid && !ov_r &&
                  (in_req.data.mode == MODE_ADD || in_req.data.mode == MODE_RATE);
  assign go = !ov_r || out_rsp.ready;
  assign fire = active_r[rd_addr] && (acc_sum >= {1'b0, rd_r.period});
  assign mem_we = (st_r == S_DIV && ddone) || (st_r == S_EX && go && active_r[rd_addr]);
  assign ov_load = go && ((st_r == S_EX && fire) || st_r == S_TEND || st_r == S_ACK);

  function automatic rsp_t mk(logic [1:0] k, logic [2:0] s, logic [15:0] t,
      logic [16:0] p, logic l, logic [1:0] stt, logic la);
    rsp_t r;
    r.kind = k; r.slot_out = s; r.tag_out = t; r.service_period = p;
    r.legacy_tick = l; r.status = stt; r.last = la;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; used_r <= '0; active_r <= '0;
      cnt_r <= '0; cur_r <= PERIOD_CAP; leg_r <= '0; idx_r <= '0; we <= 1'b0;
    end else begin
      we <= mem_we;
      if (ov_load) ov_r <= 1'b1;
      else if (ov_r && out_rsp.ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_req.valid && !ov_r) begin
          q_r <= in_req.data; idx_r <= '0; best_r <= PERIOD_CAP;
          case (in_req.data.mode) inside
            MODE_TICK: st_r <= S_RD;
            MODE_ADD: st_r <= (cnt_r >= CW'(MAX_TASKS) || !has_free) ? S_ACK : S_DIV;
            MODE_REMOVE, MODE_RATE:
              if (!used_r[in_req.data.slot[SW-1:0]] ||
                  32'(in_req.data.slot) >= MAX_TASKS) st_r <= S_ACK;
              else if (in_req.data.mode == MODE_RATE) st_r <= S_DIV;
              else begin
                for (int i = 0; i < MAX_TASKS; i++) begin
                  logic hit;
                  hit = 1'b0;
                  for (int j = 0; j <= i; j++)
                    if (CW'(j) < cnt_r && ord_r[j] == in_req.data.slot[SW-1:0]) hit = 1'b1;
                  if (hit && i + 1 < MAX_TASKS) ord_r[i] <= ord_r[(i + 1) % MAX_TASKS];
                end
                cnt_r <= cnt_r - CW'(1);
                used_r[in_req.data.slot[SW-1:0]] <= 1'b0;
                active_r[in_req.data.slot[SW-1:0]] <= 1'b0;
                st_r <= S_SCAN;
              end
            MODE_START: begin active_r <= used_r; st_r <= S_ACK; end
            MODE_CLEAR: begin
              used_r <= '0; active_r <= '0; cnt_r <= '0; cur_r <= PERIOD_CAP;
              leg_r <= '0; st_r <= S_ACK;
            end
            default: st_r <= S_ACK;
          endcase
        end
        S_DIV: if (ddone) begin
          if (q_r.mode == MODE_ADD) begin
            wa <= free_s;
            wd <= '{period: dq, accum: '0, tag: q_r.task_id};
            used_r[free_s] <= 1'b1; active_r[free_s] <= 1'b0;
            prio_r[free_s] <= q_r.priority_req;
            if (dq < {4'd0, cur_r}) cur_r <= dq[16:0];
            for (int i = 0; i < MAX_TASKS; i++) begin
              logic before_ok, prev_ok;
              before_ok = CW'(i) < cnt_r && prio_r[ord_r[i]] < q_r.priority_req;
              prev_ok = 1'b1;
              for (int j = 0; j < i; j++)
                if (!(CW'(j) < cnt_r && prio_r[ord_r[j]] < q_r.priority_req)) prev_ok = 1'b0;
              if (!(before_ok && prev_ok)) begin
                if (prev_ok) ord_r[i] <= free_s;
                else if (i > 0) ord_r[i] <= ord_r[(i + MAX_TASKS - 1) % MAX_TASKS];
              end
            end
            cnt_r <= cnt_r + CW'(1);
            st_r <= S_ACK;
          end else begin
            wa <= q_r.slot[SW-1:0];
            wd <= '{period: dq, accum: rd_r.accum, tag: rd_r.tag};
            st_r <= S_INS;
          end
        end
        S_INS: st_r <= S_SCAN;
        S_SCAN: begin
          if (idx_r >= cnt_r) begin
            cur_r <= best_r; st_r <= S_ACK;
          end else st_r <= S_OUT;
        end
        S_OUT: begin
          if ({4'd0, best_r} > rd_r.period) best_r <= rd_r.period[16:0];
          idx_r <= idx_r + CW'(1); st_r <= S_SCAN;
        end
        S_RD: begin
          if (idx_r >= cnt_r) st_r <= S_TEND;
          else st_r <= S_EX;
        end
        S_EX: if (go) begin
          if (active_r[rd_addr]) begin
            wa <= rd_addr;
            if (fire) begin
              wd <= '{period: rd_r.period, accum: acc_sum - {1'b0, rd_r.period},
                      tag: rd_r.tag};
              o_r <= mk(KIND_FIRE, 3'(rd_addr), rd_r.tag, cur_r, 1'b0, ST_OK, 1'b0);
            end else wd <= '{period: rd_r.period, accum: acc_sum, tag: rd_r.tag};
          end
          idx_r <= idx_r + CW'(1); st_r <= S_RD;
        end
        S_TEND: if (go) begin
          leg_r <= leg_sum[15:0];
          o_r <= mk(KIND_TICK, 3'd0, 16'd0, cur_r, leg_sum[16], ST_OK, 1'b1);
          st_r <= S_IDLE;
        end
        S_ACK: if (go) begin
          if (q_r.mode == MODE_ADD && wa_ok_r)
            o_r <= mk(KIND_ACK, 3'(wa), q_r.task_id, cur_r, 1'b0, ST_OK, 1'b1);
          else if (q_r.mode == MODE_ADD)
            o_r <= mk(KIND_ACK, 3'd0, 16'd0, cur_r, 1'b0, ST_FULL, 1'b1);
          else if ((q_r.mode == MODE_REMOVE || q_r.mode == MODE_RATE) && !ok_r)
            o_r <= mk(KIND_ACK, 3'd0, 16'd0, cur_r, 1'b0, ST_FREE, 1'b1);
          else o_r <= mk(KIND_ACK, 3'd0, 16'd0, cur_r, 1'b0, ST_OK, 1'b1);
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_ok_r <= 1'b0; ok_r <= 1'b0;
    end else if (st_r == S_IDLE && in_req.valid && !ov_r) begin
      wa_ok_r <= 1'b0;
      ok_r <= used_r[in_req.data.slot[SW-1:0]] && 32'(in_req.data.slot) < MAX_TASKS;
    end else if (st_r == S_DIV && ddone && q_r.mode == MODE_ADD) begin
      wa_ok_r <= 1'b1;
    end
  end
endmodule
